// File: rtl/ihcc_pkg.sv
package ihcc_pkg;

  // Header layout
  localparam int HEADER_BYTES = 16;
  localparam int SIZE_BYTES   = 8;
  localparam int CRC_SPAN     = 12;
  localparam int FIELD_END    = 16;

  // Byte position counter, saturates at HEADER_BYTES
  localparam int IDX_W = $clog2(HEADER_BYTES + 1);
  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t IDX_ZERO    = IDX_W'(0);
  localparam idx_t IDX_SIZE    = IDX_W'(SIZE_BYTES);
  localparam idx_t IDX_SPAN    = IDX_W'(CRC_SPAN);
  localparam idx_t IDX_FEND    = IDX_W'(FIELD_END);
  localparam idx_t IDX_LAST    = IDX_W'(HEADER_BYTES - 1);
  localparam idx_t IDX_SAT     = IDX_W'(HEADER_BYTES);

  // Configuration registers
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CRC_POLY = 1'b0,
    REG_CRC_SEED = 1'b1
  } cfg_reg_t;

  localparam logic [31:0] CRC_POLY_RST = 32'hEDB8_8320;
  localparam logic [31:0] CRC_SEED_RST = 32'hFFFF_FFFF;

  // Current configuration
  typedef struct packed {
    logic [31:0] poly;
    logic [31:0] seed;
  } crc_cfg_t;

  // One parsed header result
  typedef struct packed {
    logic [63:0] payload_size;
    logic [31:0] image_version;
    logic [31:0] stored_crc;
    logic [31:0] calc_crc;
    logic        crc_match;
  } hdr_res_t;

  // Reflected CRC-32, one byte: eight shift/xor steps
  function automatic logic [31:0] crc_byte(input logic [31:0] acc,
                                           input logic [7:0]  b,
                                           input logic [31:0] poly);
    logic [31:0] a;
    a = acc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      if (a[0]) begin
        a = (a >> 1) ^ poly;
      end else begin
        a = a >> 1;
      end
    end
    return a;
  endfunction

endpackage

// File: rtl/ihcc_cfg_regs.sv
module ihcc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ihcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output ihcc_pkg::crc_cfg_t             cfg
);

  logic [31:0] poly_r;
  logic [31:0] seed_r;

  // Register writes on a completed transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= ihcc_pkg::CRC_POLY_RST;
      seed_r <= ihcc_pkg::CRC_SEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (ihcc_pkg::cfg_reg_t'(cfg_index))
        ihcc_pkg::REG_CRC_POLY: poly_r <= cfg_data;
        ihcc_pkg::REG_CRC_SEED: seed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.poly = poly_r;
  assign cfg.seed = seed_r;

endmodule

// File: rtl/ihcc_parse.sv
module ihcc_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               start_req,
  input  ihcc_pkg::crc_cfg_t cfg,
  output logic               res_valid,
  output ihcc_pkg::hdr_res_t res
);

  ihcc_pkg::idx_t byte_index_r, byte_index_nxt;
  logic [31:0]    crc_acc_r, crc_acc_nxt;
  logic [63:0]    size_r, size_nxt;
  logic [31:0]    version_r, version_nxt;
  logic [31:0]    crc_field_r, crc_field_nxt;

  ihcc_pkg::idx_t idx;
  logic           in_hdr;
  logic [31:0]    crc_base;
  logic [63:0]    size_base;
  logic [31:0]    version_base;
  logic [31:0]    crc_field_base;
  logic [31:0]    computed;

  // Position of this byte; start resyncs to byte 0
  assign idx    = start_req ? ihcc_pkg::IDX_ZERO : byte_index_r;
  assign in_hdr = (idx < ihcc_pkg::IDX_SAT);

  // Byte 0 reloads the seed and clears the fields
  always_comb begin
    if (idx == ihcc_pkg::IDX_ZERO) begin
      crc_base       = cfg.seed;
      size_base      = '0;
      version_base   = '0;
      crc_field_base = '0;
    end else begin
      crc_base       = crc_acc_r;
      size_base      = size_r;
      version_base   = version_r;
      crc_field_base = crc_field_r;
    end
  end

  // Field assembly and CRC update
  always_comb begin
    size_nxt       = size_base;
    version_nxt    = version_base;
    crc_field_nxt  = crc_field_base;
    crc_acc_nxt    = crc_base;
    if (idx < ihcc_pkg::IDX_SIZE) begin
      size_nxt = {size_base[55:0], data_byte};
    end else if (idx < ihcc_pkg::IDX_SPAN) begin
      version_nxt = {version_base[23:0], data_byte};
    end else if (idx < ihcc_pkg::IDX_FEND) begin
      crc_field_nxt = {crc_field_base[23:0], data_byte};
    end
    if (idx < ihcc_pkg::IDX_SPAN) begin
      crc_acc_nxt = ihcc_pkg::crc_byte(crc_base, data_byte, cfg.poly);
    end
  end

  assign byte_index_nxt = in_hdr ? idx + ihcc_pkg::IDX_W'(1) : byte_index_r;

  // State registers, written only on an accepted byte inside the header
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= ihcc_pkg::IDX_ZERO;
    end else if (accept) begin
      byte_index_r <= byte_index_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_hdr) begin
      crc_acc_r   <= crc_acc_nxt;
      size_r      <= size_nxt;
      version_r   <= version_nxt;
      crc_field_r <= crc_field_nxt;
    end
  end

  // Result on the last header byte
  assign computed  = crc_acc_nxt ^ cfg.seed;
  assign res_valid = accept && (idx == ihcc_pkg::IDX_LAST);

  assign res.payload_size  = size_nxt;
  assign res.image_version = version_nxt;
  assign res.stored_crc    = crc_field_nxt;
  assign res.calc_crc      = computed;
  assign res.crc_match     = (computed == crc_field_nxt);

endmodule

// File: rtl/ihcc_out_reg.sv
module ihcc_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  ihcc_pkg::hdr_res_t res,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               hold,
  output ihcc_pkg::hdr_res_t out_res
);

  logic               valid_r, valid_nxt;
  ihcc_pkg::hdr_res_t res_r;

  // Slot is held while a result waits on a stalled receiver
  assign hold = valid_r && out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// File: rtl/image_header_crc_check.sv
// Channel | Direction | Handshake             | Payload
// in_     | input     | in_valid / in_stall   | data_byte, start_req
// out_    | output    | out_valid / out_stall | payload_size .. crc_match
// cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One byte is taken every cycle while in_stall is low; its CRC step (eight shift/xor stages) and
// field shift settle in the same cycle. The result of the last header byte
// appears in the result register on the next cycle.
// Reset (rst_n low, synchronous) clears the byte counter and result valid;
// configuration returns to the standard CRC-32 polynomial and seed.
// in_stall is high only while a result is held by out_stall.
module image_header_crc_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_start_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [63:0]                    out_payload_size,
  output logic [31:0]                    out_image_version,
  output logic [31:0]                    out_stored_crc,
  output logic [31:0]                    out_calc_crc,
  output logic                           out_crc_match,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ihcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  ihcc_pkg::crc_cfg_t cfg;
  ihcc_pkg::hdr_res_t res;
  ihcc_pkg::hdr_res_t out_res;
  logic               res_valid;
  logic               hold;
  logic               in_xfer;

  assign cfg_ready = 1'b1;
  assign in_stall  = hold;
  assign in_xfer   = in_valid && !in_stall;

  ihcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ihcc_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_xfer),
    .data_byte (in_data_byte),
    .start_req (in_start_req),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  ihcc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .hold      (hold),
    .out_res   (out_res)
  );

  assign out_payload_size  = out_res.payload_size;
  assign out_image_version = out_res.image_version;
  assign out_stored_crc    = out_res.stored_crc;
  assign out_calc_crc      = out_res.calc_crc;
  assign out_crc_match     = out_res.crc_match;

  // Match flag agrees with the fields it was built from
  a_match_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_crc_match == (out_calc_crc == out_stored_crc)))
    else $error("crc_match disagrees with computed and stored CRC");

  // Input is only held back by a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty result register");

  // A new result never overwrites one still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !(out_valid && out_stall))
    else $error("result produced while result register is held");

  // A held result stays in place on the next cycle
  a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    hold |=> (out_valid && $stable(out_calc_crc)))
    else $error("held result lost or changed");

endmodule

// File: verif/ihcc_checker.sv
package ihcc_tb_pkg;

  // Reflected CRC-32 update over one byte, LSB first
  function automatic logic [31:0] crc32r_step(input logic [31:0] acc,
                                              input logic [7:0]  din,
                                              input logic [31:0] poly);
    logic [31:0] r;
    r = acc ^ {24'h0, din};
    for (int n = 0; n < 8; n++) begin
      r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

module ihcc_checker
  import ihcc_pkg::*;
  import ihcc_tb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_start_req,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [63:0]          out_payload_size,
  input  logic [31:0]          out_image_version,
  input  logic [31:0]          out_stored_crc,
  input  logic [31:0]          out_calc_crc,
  input  logic                 out_crc_match,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the block: configuration, running CRC and field shifters
  crc_cfg_t    crc_now;
  logic [31:0] run_crc;
  idx_t        byte_pos;
  logic [63:0] size_acc;
  logic [31:0] ver_acc;
  logic [31:0] stored_acc;
  hdr_res_t    hdr_expect_q[$];

  // Advance the header parser by one accepted byte
  task automatic parse_header_byte(input logic [7:0] b, input logic sop);
    idx_t     pos;
    hdr_res_t res;
    pos = sop ? IDX_ZERO : byte_pos;
    // past the header and no resync: byte is dropped
    if (pos < IDX_SAT) begin
      if (pos == IDX_ZERO) begin
        run_crc    = crc_now.seed;
        size_acc   = '0;
        ver_acc    = '0;
        stored_acc = '0;
      end
      if (pos < IDX_SIZE) begin
        size_acc = {size_acc[55:0], b};
      end else if (pos < IDX_SPAN) begin
        ver_acc = {ver_acc[23:0], b};
      end else if (pos < IDX_FEND) begin
        stored_acc = {stored_acc[23:0], b};
      end
      if (pos < IDX_SPAN) begin
        run_crc = crc32r_step(run_crc, b, crc_now.poly);
      end
      byte_pos = pos + IDX_W'(1);
      if (pos == IDX_LAST) begin
        res.payload_size  = size_acc;
        res.image_version = ver_acc;
        res.stored_crc    = stored_acc;
        res.calc_crc      = run_crc ^ crc_now.seed;
        res.crc_match     = (res.calc_crc == stored_acc);
        hdr_expect_q      = {hdr_expect_q, res};
      end
    end
  endtask

  // Compare one result transfer against the oldest expected header
  task automatic check_header_result();
    hdr_res_t want;
    bit       bad;
    if (hdr_expect_q.size() == 0) begin
      $display("%0t ERROR: unexpected result: expected none, got size %h ver %h crc %h/%h m %b",
               $time, out_payload_size, out_image_version, out_stored_crc,
               out_calc_crc, out_crc_match);
      fail_count++;
    end else begin
      want = hdr_expect_q.pop_front();
      bad  = 1'b0;
      if (out_payload_size !== want.payload_size) begin
        $display("%0t ERROR: payload_size expected %h got %h",
                 $time, want.payload_size, out_payload_size);
        bad = 1'b1;
      end
      if (out_image_version !== want.image_version) begin
        $display("%0t ERROR: image_version expected %h got %h",
                 $time, want.image_version, out_image_version);
        bad = 1'b1;
      end
      if (out_stored_crc !== want.stored_crc) begin
        $display("%0t ERROR: stored_crc expected %h got %h",
                 $time, want.stored_crc, out_stored_crc);
        bad = 1'b1;
      end
      if (out_calc_crc !== want.calc_crc) begin
        $display("%0t ERROR: calc_crc expected %h got %h",
                 $time, want.calc_crc, out_calc_crc);
        bad = 1'b1;
      end
      if (out_crc_match !== want.crc_match) begin
        $display("%0t ERROR: crc_match expected %b got %b",
                 $time, want.crc_match, out_crc_match);
        bad = 1'b1;
      end
      if (bad) begin
        fail_count++;
      end
    end
  endtask

  // Result first, then config, then the new byte: a result is registered after its last
  // byte is taken, so it never meets its own prediction on one edge
  always @(posedge clk) begin
    if (!rst_n) begin
      crc_now.poly = CRC_POLY_RST;
      crc_now.seed = CRC_SEED_RST;
      run_crc      = CRC_SEED_RST;
      byte_pos     = IDX_ZERO;
      size_acc     = '0;
      ver_acc      = '0;
      stored_acc   = '0;
      fail_count   = 0;
      hdr_expect_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        check_header_result();
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_CRC_POLY: crc_now.poly = cfg_data;
          REG_CRC_SEED: crc_now.seed = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        parse_header_byte(in_data_byte, in_start_req);
      end
    end
    pending = hdr_expect_q.size();
  end

endmodule

// File: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ihcc_pkg::*;
  import ihcc_tb_pkg::*;

  localparam int NUM_PHASES = 6;
  localparam int PHASE_BYTES = 55;
  localparam int HOLD_CYCLES = 300;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_data_byte;
  logic                 in_start_req;
  logic                 out_valid;
  logic                 out_stall;
  logic [63:0]          out_payload_size;
  logic [31:0]          out_image_version;
  logic [31:0]          out_stored_crc;
  logic [31:0]          out_calc_crc;
  logic                 out_crc_match;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  int                   fail_count;
  int                   pending;

  // Stimulus knobs, each written by the main process only
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          hold_req = 0;
  int          bytes_sent = 0;
  logic [31:0] cur_poly = CRC_POLY_RST;
  logic [31:0] cur_seed = CRC_SEED_RST;

  always #5 clk = ~clk;

  image_header_crc_check uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_start_req      (in_start_req),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_size  (out_payload_size),
    .out_image_version (out_image_version),
    .out_stored_crc    (out_stored_crc),
    .out_calc_crc      (out_calc_crc),
    .out_crc_match     (out_crc_match),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  ihcc_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_start_req      (in_start_req),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_size  (out_payload_size),
    .out_image_version (out_image_version),
    .out_stored_crc    (out_stored_crc),
    .out_calc_crc      (out_calc_crc),
    .out_crc_match     (out_crc_match),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  // Byte values weighted toward the extremes
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(7);
    if (r == 0) begin
      return 8'h00;
    end else if (r == 1) begin
      return 8'hFF;
    end
    return 8'($urandom_range(255));
  endfunction

  // CRC the block should report for bytes 0-11 under the current config
  function automatic logic [31:0] header_crc(input logic [7:0] h [16]);
    logic [31:0] acc;
    acc = cur_seed;
    for (int k = 0; k < CRC_SPAN; k++) begin
      acc = crc32r_step(acc, h[k], cur_poly);
    end
    return acc ^ cur_seed;
  endfunction

  // One byte transfer; random idle cycles ahead of it, ends at the accepting edge
  task automatic send_byte(input logic [7:0] b, input logic sop);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_start_req <= sop;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Drop valid and wait out every expected result plus the pipeline tail
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_CRC_POLY) begin
      cur_poly = val;
    end else begin
      cur_seed = val;
    end
  endtask

  // Start a header, reconfigure in the middle of it, then finish it
  task automatic reconfig_mid_header(input logic [31:0] poly, input logic [31:0] seed);
    int head;
    head = $urandom_range(1, 11);
    for (int k = 0; k < head; k++) begin
      send_byte(pick_byte(), k == 0);
    end
    drain_results();
    write_reg(REG_CRC_POLY, poly);
    write_reg(REG_CRC_SEED, seed);
    for (int k = head; k < HEADER_BYTES; k++) begin
      send_byte(pick_byte(), 1'b0);
    end
  endtask

  // Mostly whole headers (half with a good CRC), some cut short, some noise
  task automatic send_random_unit();
    logic [7:0] hdr [16];
    int         r;
    int         n;
    r = $urandom_range(99);
    for (int k = 0; k < HEADER_BYTES; k++) begin
      hdr[k] = pick_byte();
    end
    if (r < 70) begin
      if ($urandom_range(1) == 1) begin
        {hdr[12], hdr[13], hdr[14], hdr[15]} = header_crc(hdr);
      end
      for (int k = 0; k < HEADER_BYTES; k++) begin
        send_byte(hdr[k], k == 0);
      end
      n = $urandom_range(3);
      repeat (n) send_byte(pick_byte(), 1'b0);
    end else if (r < 85) begin
      n = $urandom_range(1, 15);
      for (int k = 0; k < n; k++) begin
        send_byte(hdr[k], k == 0);
      end
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(pick_byte(), $urandom_range(3) == 0);
    end
  endtask

  // Result side: random stall, or a long hold-off when one is requested
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("image_header_crc_check verification failed");
    $finish;
  end

  initial begin
    logic [7:0]  hdr [16];
    logic [31:0] poly_set [NUM_PHASES];
    logic [31:0] seed_set [NUM_PHASES];
    int          phase_end;

    poly_set = '{32'hEDB8_8320, 32'h0000_0000, 32'hFFFF_FFFF,
                 32'h82F6_3B78, 32'($urandom), CRC_POLY_RST};
    seed_set = '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'($urandom), 32'h1234_5678};

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    in_start_req = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_CRC_POLY;
    cfg_data     = 32'h0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset config: first header has no start flag, max size,
    // zero version and a correct CRC
    for (int k = 0; k < HEADER_BYTES; k++) begin
      hdr[k] = (k < SIZE_BYTES) ? 8'hFF : 8'h00;
    end
    {hdr[12], hdr[13], hdr[14], hdr[15]} = header_crc(hdr);
    for (int k = 0; k < HEADER_BYTES; k++) begin
      send_byte(hdr[k], 1'b0);
    end
    // bytes past the header are dropped
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // start, then a second start in the middle resyncs to byte zero
    send_byte(8'h5A, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'hFF, 1'b0);

    // Random phases, each opened by a config change in the middle of a header
    for (int p = 0; p < NUM_PHASES; p++) begin
      reconfig_mid_header(poly_set[p], seed_set[p]);
      if (p < 2) begin
        snd_idle_pct = 37;
        rcv_idle_pct = 82;
      end else if (p < 4) begin
        snd_idle_pct = 82;
        rcv_idle_pct = 37;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      if (p == 4) begin
        hold_req++;
      end
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        send_random_unit();
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("image_header_crc_check verification clean");
    end else begin
      $display("image_header_crc_check verification failed");
    end
    $finish;
  end

endmodule
